[src/lbog_pkg.sv]
// Shared types and constants of the laser beam occupancy grid update unit.
// No dependencies; every other file but lbog_req_if.sv refers to it by scoped names.
package lbog_pkg;

   // Sample positions need 34 bits plus the map offset; 48 covers every legal grid and FRAC_BITS.
   localparam int POS_W = 48;

   localparam int SIN_A = 51472;
   localparam int SIN_B = 21166;
   localparam int SIN_C = 2462;

   localparam int ADDR_W = 5;

   localparam logic CMD_LANDMARK = 1'b1;

   localparam logic [1:0] CLASS_FREE      = 2'd0;
   localparam logic [1:0] CLASS_UNDECIDED = 2'd1;
   localparam logic [1:0] CLASS_OCCUPIED  = 2'd2;

   typedef enum logic [2:0] {
      REG_ANGLE_START,
      REG_ANGLE_STEP,
      REG_RANGE_LOWER,
      REG_RANGE_UPPER,
      REG_FREE_INC,
      REG_OCC_INC,
      REG_OCC_LIMIT,
      REG_FREE_LIMIT
   } reg_index_type;

   typedef struct packed {
      logic [15:0]        angle_start;
      logic [15:0]        angle_step;
      logic [13:0]        range_lower;
      logic [13:0]        range_upper;
      logic signed [15:0] free_inc;
      logic [14:0]        occ_inc;
      logic signed [15:0] occ_limit;
      logic signed [15:0] free_limit;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [15:0]        heading;
      logic [9:0]         beam_number;
      logic [15:0]        beam_range;
   } item_type;

   typedef struct packed {
      logic [15:0]        cell_index;
      logic [1:0]         cell_class;
      logic signed [15:0] cell_log_odds;
      logic               last;
   } result_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_ANGLE,
      OP_SIN_GO,
      OP_SIN_SAVE,
      OP_COS_GO,
      OP_COS_SAVE,
      OP_WALK_INIT,
      OP_SNAP,
      OP_SQX,
      OP_SQY,
      OP_DECIDE,
      OP_UPDATE,
      OP_ADVANCE,
      OP_END_X,
      OP_END_Y,
      OP_FLUSH
   } op_type;

   typedef enum logic [1:0] {
      PH_SAMPLE,
      PH_END,
      PH_LANDMARK
   } phase_type;

   typedef struct packed {
      op_type    op;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic landmark;
      logic in_range;
      logic sine_done;
      logic loop_more;
      logic in_map;
      logic emit_ok;
      logic can_push;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

[src/lbog_req_if.sv]
// Channel interfaces for beam and landmark items and for cell results.
// Payload fields follow the item and result layout of lbog_pkg.
interface lbog_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic [15:0]        heading;
   logic [9:0]         beam_number;
   logic [15:0]        beam_range;

   modport source (output valid, cmd, point_x, point_y, heading, beam_number, beam_range,
                   input ready);
   modport sink (input valid, cmd, point_x, point_y, heading, beam_number, beam_range,
                 output ready);
endinterface

interface lbog_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        cell_index;
   logic [1:0]         cell_class;
   logic signed [15:0] cell_log_odds;
   logic               last;

   modport source (output valid, cell_index, cell_class, cell_log_odds, last, input ready);
   modport sink (input valid, cell_index, cell_class, cell_log_odds, last, output ready);
endinterface

[src/lbog_sine.sv]
// Iterative Q15 sine of a 16-bit turn angle, one multiply per cycle.
// Uses the polynomial constants of lbog_pkg.
module lbog_sine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        angle,
   output logic               done,
   output logic signed [16:0] value
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [14:0]       x_ff, x_in;
   logic [14:0]       x2_ff, x2_in;
   logic [15:0]       t_ff, t_in;
   logic signed [16:0] val_ff, val_in;

   logic [15:0] op_a, op_b;
   logic [31:0] prod;
   logic [15:0] pq;

   always_comb begin
      unique case (step_ff)
         2'd0: begin
            op_a = {1'b0, x_ff};
            op_b = {1'b0, x_ff};
         end
         2'd1: begin
            op_a = {1'b0, x2_ff};
            op_b = 16'(lbog_pkg::SIN_C);
         end
         2'd2: begin
            op_a = {1'b0, x2_ff};
            op_b = t_ff;
         end
         default: begin
            op_a = {1'b0, x_ff};
            op_b = t_ff;
         end
      endcase
      prod = op_a * op_b;
      pq   = prod[29:14];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      x2_in   = x2_ff;
      t_in    = t_ff;
      val_in  = val_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = 2'd0;
         neg_in  = angle[15];
         // Odd quadrants run the quarter wave backwards.
         x_in    = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            2'd0: x2_in = pq[14:0];
            2'd1: t_in = 16'(lbog_pkg::SIN_B) - pq;
            2'd2: t_in = 16'(lbog_pkg::SIN_A) - pq;
            default: begin
               val_in  = neg_ff ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      x_ff   <= x_in;
      x2_ff  <= x2_in;
      t_ff   <= t_in;
      val_ff <= val_in;
   end

   assign done  = done_ff;
   assign value = val_ff;

endmodule

[src/lbog_datapath.sv]
// Datapath: item registers, trig, beam walk, cell snapping, log-odds store and result registers.
// Driven by lbog_ctrl through lbog_pkg::cmd_type; uses lbog_sine and the result channel interface.
module lbog_datapath #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int MAX_STEPS   = 63,
   parameter int FRAC_BITS   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lbog_pkg::cfg_type    cfg,
   input  lbog_pkg::item_type   item,
   input  lbog_pkg::cmd_type    cmd,
   output lbog_pkg::status_type status,
   lbog_rsp_if.source           rsp
);

   localparam int PW     = lbog_pkg::POS_W;
   localparam int PS     = FRAC_BITS + 15;
   localparam int OFF_W  = PS + 1;
   localparam int SQ_W   = 2 * OFF_W;
   localparam int D_W    = SQ_W + 6;
   localparam int COL_W  = $clog2(GRID_WIDTH);
   localparam int ROW_W  = $clog2(GRID_HEIGHT);
   localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int K_W    = $clog2(MAX_STEPS + 1);
   localparam int R_W    = FRAC_BITS + K_W;
   localparam int CMP_W  = (R_W > 16 ? R_W : 16) + 3;

   localparam logic signed [PW-1:0] HALF_X = PW'(GRID_WIDTH / 2) <<< PS;
   localparam logic signed [PW-1:0] HALF_Y = PW'(GRID_HEIGHT / 2) <<< PS;
   localparam logic [OFF_W-1:0] ONE_OFF = OFF_W'(1) << PS;
   localparam logic [CMP_W-1:0] UNIT_C  = CMP_W'(1) << FRAC_BITS;
   localparam logic [R_W-1:0]   UNIT_R  = R_W'(1) << FRAC_BITS;
   localparam logic [D_W-1:0]   THIRD_LIM = D_W'(1) << (2 * PS + 2);
   localparam logic [D_W-1:0]   TENTH_LIM = D_W'(1) << (2 * PS + 4);

   // Item and walk registers
   logic signed [15:0] px_ff, py_ff;
   logic [15:0]        head_ff, rr_ff;
   logic [9:0]         num_ff;
   logic               lm_ff;
   logic [15:0]        ang_ff;
   logic signed [16:0] sn_ff, cs_ff;
   logic signed [PW-1:0] xh_ff, yh_ff;
   logic [R_W-1:0]     r_ff;
   logic [K_W-1:0]     k_ff;

   // Snap and distance registers
   logic [IDX_W-1:0]   idx_ff;
   logic               inmap_ff;
   logic [OFF_W-1:0]   offx_ff, offy_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic signed [16:0] inc_ff;
   logic               emit_ok_ff;

   // Store and results
   logic signed [15:0] log_odds_mem [DEPTH];
   logic signed [15:0] rd_ff;
   logic [IDX_W:0]     clr_cnt_ff;
   lbog_pkg::result_type pend_ff, out_ff;
   logic               pend_v_ff, out_v_ff;

   // Trig unit
   logic               sine_start, sine_done;
   logic [15:0]        sine_angle;
   logic signed [16:0] sine_value;

   lbog_sine u_sine (
      .clock (clock),
      .reset (reset),
      .start (sine_start),
      .angle (sine_angle),
      .done  (sine_done),
      .value (sine_value)
   );

   assign sine_start = (cmd.op == lbog_pkg::OP_SIN_GO) || (cmd.op == lbog_pkg::OP_COS_GO);
   assign sine_angle = (cmd.op == lbog_pkg::OP_COS_GO) ? (ang_ff + 16'd16384) : ang_ff;

   // Combinational helpers
   logic [25:0]        beam_prod;
   logic signed [PW-1:0] px_pos, py_pos;
   logic signed [33:0] end_x_prod, end_y_prod;
   logic signed [PW-1:0] ux, uy, cx, cy;
   logic [OFF_W-1:0]   tx, ty, offx_n, offy_n;
   logic               inmap_n;
   logic [IDX_W-1:0]   idx_n;
   logic [SQ_W:0]      d2;
   logic [D_W-1:0]     d9, d25;
   logic               near, near_end;
   logic [CMP_W-1:0]   two_r, two_rr;
   logic               free_ok, occ_ok, loop_more;
   logic signed [16:0] occ_inc_s, free_inc_s;
   logic signed [17:0] sum;
   logic signed [15:0] new_val;
   logic [1:0]         new_class;
   logic [31:0]        idx_wide;
   logic               out_free, can_push, clr_done;
   logic               rng_ok;

   always_comb begin
      beam_prod  = num_ff * cfg.angle_step;
      px_pos     = PW'(px_ff) <<< 15;
      py_pos     = PW'(py_ff) <<< 15;
      end_x_prod = $signed({1'b0, rr_ff}) * cs_ff;
      end_y_prod = $signed({1'b0, rr_ff}) * sn_ff;

      // Nearest centre by floor after shifting the origin to the map corner.
      ux = xh_ff + HALF_X;
      uy = yh_ff + HALF_Y;
      cx = ux >>> PS;
      cy = uy >>> PS;
      tx = {ux[PS-1:0], 1'b0};
      ty = {uy[PS-1:0], 1'b0};
      offx_n = (tx >= ONE_OFF) ? (tx - ONE_OFF) : (ONE_OFF - tx);
      offy_n = (ty >= ONE_OFF) ? (ty - ONE_OFF) : (ONE_OFF - ty);
      inmap_n = (cx >= 0) && (cx < PW'(GRID_WIDTH)) && (cy >= 0) && (cy < PW'(GRID_HEIGHT));
      idx_n = IDX_W'(cy[ROW_W-1:0]) * IDX_W'(GRID_WIDTH) + IDX_W'(cx[COL_W-1:0]);

      d2       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      d9       = (D_W'(d2) << 3) + D_W'(d2);
      d25      = (D_W'(d2) << 4) + (D_W'(d2) << 3) + D_W'(d2);
      near     = d9 < THIRD_LIM;
      near_end = d25 < TENTH_LIM;

      two_r     = CMP_W'(r_ff) << 1;
      two_rr    = CMP_W'(rr_ff) << 1;
      free_ok   = (two_r + UNIT_C) <= two_rr;
      occ_ok    = two_r >= (two_rr + UNIT_C);
      loop_more = (k_ff < K_W'(MAX_STEPS)) && (CMP_W'(r_ff) < (CMP_W'(rr_ff) + UNIT_C));

      occ_inc_s  = $signed({2'b00, cfg.occ_inc});
      free_inc_s = 17'(cfg.free_inc);

      sum = 18'(rd_ff) + 18'(inc_ff);
      if (sum > 18'sd32767)
         new_val = 16'sh7FFF;
      else if (sum < -18'sd32768)
         new_val = -16'sh8000;
      else
         new_val = sum[15:0];
      if (new_val >= cfg.occ_limit)
         new_class = lbog_pkg::CLASS_OCCUPIED;
      else if (new_val <= cfg.free_limit)
         new_class = lbog_pkg::CLASS_FREE;
      else
         new_class = lbog_pkg::CLASS_UNDECIDED;
      idx_wide = 32'(idx_ff);

      out_free = !out_v_ff || rsp.ready;
      can_push = !pend_v_ff || out_free;
      clr_done = clr_cnt_ff == (IDX_W + 1)'(DEPTH);
      rng_ok   = (rr_ff < {2'b00, cfg.range_upper}) && (rr_ff >= {2'b00, cfg.range_lower});
   end

   always_comb begin
      status.clr_done   = clr_done;
      status.landmark   = lm_ff == lbog_pkg::CMD_LANDMARK;
      status.in_range   = rng_ok;
      status.sine_done  = sine_done;
      status.loop_more  = loop_more;
      status.in_map     = inmap_ff;
      status.emit_ok    = emit_ok_ff;
      status.can_push   = can_push;
      status.pend_valid = pend_v_ff;
      status.out_free   = out_free;
   end

   logic do_update, do_flush, do_clear;
   assign do_update = (cmd.op == lbog_pkg::OP_UPDATE) && can_push;
   assign do_flush  = (cmd.op == lbog_pkg::OP_FLUSH) && pend_v_ff && out_free;
   assign do_clear  = (cmd.op == lbog_pkg::OP_CLEAR) && !clr_done;

   // Payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         lbog_pkg::OP_LOAD: begin
            lm_ff   <= item.cmd;
            px_ff   <= item.point_x;
            py_ff   <= item.point_y;
            head_ff <= item.heading;
            num_ff  <= item.beam_number;
            rr_ff   <= item.beam_range;
         end
         lbog_pkg::OP_ANGLE: ang_ff <= cfg.angle_start + beam_prod[15:0] + head_ff;
         lbog_pkg::OP_SIN_SAVE: begin
            if (sine_done)
               sn_ff <= sine_value;
         end
         lbog_pkg::OP_COS_SAVE: begin
            if (sine_done)
               cs_ff <= sine_value;
         end
         lbog_pkg::OP_WALK_INIT: begin
            xh_ff <= px_pos;
            yh_ff <= py_pos;
            r_ff  <= '0;
            k_ff  <= '0;
         end
         lbog_pkg::OP_SNAP: begin
            idx_ff   <= idx_n;
            inmap_ff <= inmap_n;
            offx_ff  <= offx_n;
            offy_ff  <= offy_n;
         end
         lbog_pkg::OP_SQX: sqx_ff <= offx_ff * offx_ff;
         lbog_pkg::OP_SQY: sqy_ff <= offy_ff * offy_ff;
         lbog_pkg::OP_DECIDE: begin
            unique case (cmd.phase)
               lbog_pkg::PH_SAMPLE: begin
                  emit_ok_ff <= 1'b1;
                  if (near && free_ok)
                     inc_ff <= free_inc_s;
                  else if (near && occ_ok)
                     inc_ff <= occ_inc_s;
                  else
                     inc_ff <= '0;
               end
               lbog_pkg::PH_END: begin
                  emit_ok_ff <= near_end;
                  inc_ff     <= occ_inc_s;
               end
               default: begin
                  emit_ok_ff <= near;
                  inc_ff     <= occ_inc_s;
               end
            endcase
         end
         lbog_pkg::OP_ADVANCE: begin
            xh_ff <= xh_ff + (PW'(cs_ff) <<< FRAC_BITS);
            yh_ff <= yh_ff + (PW'(sn_ff) <<< FRAC_BITS);
            r_ff  <= r_ff + UNIT_R;
            k_ff  <= k_ff + K_W'(1);
         end
         lbog_pkg::OP_END_X: xh_ff <= px_pos + PW'(end_x_prod);
         lbog_pkg::OP_END_Y: yh_ff <= py_pos + PW'(end_y_prod);
         default: ;
      endcase
      if (do_update) begin
         pend_ff.cell_index    <= idx_wide[15:0];
         pend_ff.cell_class    <= new_class;
         pend_ff.cell_log_odds <= new_val;
         pend_ff.last          <= 1'b0;
      end
      if (do_update && pend_v_ff)
         out_ff <= pend_ff;
      else if (do_flush)
         out_ff <= '{cell_index: pend_ff.cell_index, cell_class: pend_ff.cell_class,
                     cell_log_odds: pend_ff.cell_log_odds, last: 1'b1};
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         if (do_clear)
            clr_cnt_ff <= clr_cnt_ff + (IDX_W + 1)'(1);
         if (do_update)
            pend_v_ff <= 1'b1;
         else if (do_flush)
            pend_v_ff <= 1'b0;
         if ((do_update && pend_v_ff) || do_flush)
            out_v_ff <= 1'b1;
         else if (rsp.ready)
            out_v_ff <= 1'b0;
      end
   end

   // Log-odds store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_clear)
         log_odds_mem[clr_cnt_ff[IDX_W-1:0]] <= '0;
      else if (do_update)
         log_odds_mem[idx_ff] <= new_val;
      rd_ff <= log_odds_mem[idx_ff];
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.cell_index    = out_ff.cell_index;
   assign rsp.cell_class    = out_ff.cell_class;
   assign rsp.cell_log_odds = out_ff.cell_log_odds;
   assign rsp.last          = out_ff.last;

   unused_head_check: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == lbog_pkg::OP_UPDATE) |-> (!pend_v_ff || out_free))
      else $error("store update issued while the result registers are full");

endmodule

[src/lbog_ctrl.sv]
// Controller state machine: sequences trig, the beam walk, the end point and result flushing.
// Talks to lbog_datapath only through lbog_pkg::cmd_type and lbog_pkg::status_type.
module lbog_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lbog_pkg::status_type status,
   output lbog_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ANGLE,
      ST_SIN_GO,
      ST_SIN_WAIT,
      ST_COS_GO,
      ST_COS_WAIT,
      ST_WALK_INIT,
      ST_STEP_TEST,
      ST_SNAP,
      ST_SQX,
      ST_SQY,
      ST_DECIDE,
      ST_UPDATE,
      ST_NEXT,
      ST_END_X,
      ST_END_Y,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   lbog_pkg::phase_type phase_ff;
   state_type           skip_dest;

   // Samples continue the walk; the end point and landmarks close the transaction.
   assign skip_dest = (phase_ff == lbog_pkg::PH_SAMPLE) ? ST_NEXT : ST_FINISH;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= lbog_pkg::PH_SAMPLE;
      end else begin
         unique case (state_ff)
            ST_CLEAR:    if (status.clr_done) state_ff <= ST_IDLE;
            ST_IDLE:     if (req_valid) state_ff <= ST_DISPATCH;
            ST_DISPATCH: begin
               if (status.landmark) begin
                  phase_ff <= lbog_pkg::PH_LANDMARK;
                  state_ff <= ST_WALK_INIT;
               end else if (!status.in_range) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_ANGLE;
               end
            end
            ST_ANGLE:    state_ff <= ST_SIN_GO;
            ST_SIN_GO:   state_ff <= ST_SIN_WAIT;
            ST_SIN_WAIT: if (status.sine_done) state_ff <= ST_COS_GO;
            ST_COS_GO:   state_ff <= ST_COS_WAIT;
            ST_COS_WAIT: begin
               if (status.sine_done) begin
                  phase_ff <= lbog_pkg::PH_SAMPLE;
                  state_ff <= ST_WALK_INIT;
               end
            end
            ST_WALK_INIT: begin
               state_ff <= (phase_ff == lbog_pkg::PH_LANDMARK) ? ST_SNAP : ST_STEP_TEST;
            end
            ST_STEP_TEST: begin
               if (status.loop_more) begin
                  state_ff <= ST_SNAP;
               end else begin
                  phase_ff <= lbog_pkg::PH_END;
                  state_ff <= ST_END_X;
               end
            end
            ST_SNAP:     state_ff <= ST_SQX;
            ST_SQX:      state_ff <= status.in_map ? ST_SQY : skip_dest;
            ST_SQY:      state_ff <= ST_DECIDE;
            ST_DECIDE:   state_ff <= ST_UPDATE;
            ST_UPDATE: begin
               if (!status.emit_ok)
                  state_ff <= skip_dest;
               else if (status.can_push)
                  state_ff <= skip_dest;
            end
            ST_NEXT:     state_ff <= ST_STEP_TEST;
            ST_END_X:    state_ff <= ST_END_Y;
            ST_END_Y:    state_ff <= ST_SNAP;
            ST_FINISH:   if (!status.pend_valid || status.out_free) state_ff <= ST_IDLE;
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.phase = phase_ff;
      req_ready = state_ff == ST_IDLE;
      unique case (state_ff)
         ST_CLEAR:     cmd.op = lbog_pkg::OP_CLEAR;
         ST_IDLE:      cmd.op = req_valid ? lbog_pkg::OP_LOAD : lbog_pkg::OP_NONE;
         ST_ANGLE:     cmd.op = lbog_pkg::OP_ANGLE;
         ST_SIN_GO:    cmd.op = lbog_pkg::OP_SIN_GO;
         ST_SIN_WAIT:  cmd.op = lbog_pkg::OP_SIN_SAVE;
         ST_COS_GO:    cmd.op = lbog_pkg::OP_COS_GO;
         ST_COS_WAIT:  cmd.op = lbog_pkg::OP_COS_SAVE;
         ST_WALK_INIT: cmd.op = lbog_pkg::OP_WALK_INIT;
         ST_SNAP:      cmd.op = lbog_pkg::OP_SNAP;
         ST_SQX:       cmd.op = lbog_pkg::OP_SQX;
         ST_SQY:       cmd.op = lbog_pkg::OP_SQY;
         ST_DECIDE:    cmd.op = lbog_pkg::OP_DECIDE;
         ST_UPDATE:    cmd.op = (status.emit_ok && status.can_push) ? lbog_pkg::OP_UPDATE
                                                                    : lbog_pkg::OP_NONE;
         ST_NEXT:      cmd.op = lbog_pkg::OP_ADVANCE;
         ST_END_X:     cmd.op = lbog_pkg::OP_END_X;
         ST_END_Y:     cmd.op = lbog_pkg::OP_END_Y;
         ST_FINISH:    cmd.op = lbog_pkg::OP_FLUSH;
         default:      cmd.op = lbog_pkg::OP_NONE;
      endcase
   end

   idle_empty_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.pend_valid)
      else $error("a held result survived the end of its transaction");

   ready_after_clear_check: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> status.clr_done)
      else $error("item accepted before the store clearing pass ended");

   update_holds_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && status.emit_ok && status.can_push) |=> status.pend_valid)
      else $error("store update did not leave a held result");

endmodule

[src/laser_beam_occupancy_grid_update_unit.sv]
// Top level of the laser beam occupancy grid update unit: register port, controller, datapath.
// Depends on lbog_pkg, lbog_req_if, lbog_rsp_if, lbog_ctrl and lbog_datapath.
//
//   port group  direction  handshake            carries
//   req_beam    in         valid/ready          beam pose and range, or landmark point
//   rsp_cell    out        valid/ready          cell index, class, log-odds, last flag
//   p*          in         APB write/read       eight configuration registers
//
// A landmark goes from dispatch straight to the walk setup and one cell test; a dropped beam
// returns to idle from dispatch. A beam runs dispatch, angle and two trig waits, then for each
// sample walked inside the map step test, snap, both squares, decide, store update and advance
// (outside it snap and the first square only), up to MAX_STEPS samples, then the end point.
// After reset a clearing pass writes zero to all GRID_WIDTH*GRID_HEIGHT entries, one per
// cycle (65536 at default size), before the first item is taken.
// A stalled result side holds the walk at its next store update.
module laser_beam_occupancy_grid_update_unit #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int MAX_STEPS   = 63,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   lbog_req_if.sink                      req_beam,
   lbog_rsp_if.source                    rsp_cell,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lbog_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   lbog_pkg::cfg_type    cfg_ff;
   lbog_pkg::item_type   item;
   lbog_pkg::cmd_type    cmd;
   lbog_pkg::status_type status;
   lbog_pkg::reg_index_type reg_sel;

   assign reg_sel = lbog_pkg::reg_index_type'(paddr[lbog_pkg::ADDR_W-1:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_start <= 16'd0;
         cfg_ff.angle_step  <= 16'd182;
         cfg_ff.range_lower <= 14'd0;
         cfg_ff.range_upper <= 14'd15872;
         cfg_ff.free_inc    <= -16'sd216;
         cfg_ff.occ_inc     <= 15'd216;
         cfg_ff.occ_limit   <= 16'sd100;
         cfg_ff.free_limit  <= -16'sd100;
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            lbog_pkg::REG_ANGLE_START: cfg_ff.angle_start <= pwdata[15:0];
            lbog_pkg::REG_ANGLE_STEP:  cfg_ff.angle_step  <= pwdata[15:0];
            lbog_pkg::REG_RANGE_LOWER: cfg_ff.range_lower <= pwdata[13:0];
            lbog_pkg::REG_RANGE_UPPER: cfg_ff.range_upper <= pwdata[13:0];
            lbog_pkg::REG_FREE_INC:    cfg_ff.free_inc    <= pwdata[15:0];
            lbog_pkg::REG_OCC_INC:     cfg_ff.occ_inc     <= pwdata[14:0];
            lbog_pkg::REG_OCC_LIMIT:   cfg_ff.occ_limit   <= pwdata[15:0];
            default:                   cfg_ff.free_limit  <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         lbog_pkg::REG_ANGLE_START: prdata = 32'(cfg_ff.angle_start);
         lbog_pkg::REG_ANGLE_STEP:  prdata = 32'(cfg_ff.angle_step);
         lbog_pkg::REG_RANGE_LOWER: prdata = 32'(cfg_ff.range_lower);
         lbog_pkg::REG_RANGE_UPPER: prdata = 32'(cfg_ff.range_upper);
         lbog_pkg::REG_FREE_INC:    prdata = {16'd0, cfg_ff.free_inc};
         lbog_pkg::REG_OCC_INC:     prdata = 32'(cfg_ff.occ_inc);
         lbog_pkg::REG_OCC_LIMIT:   prdata = {16'd0, cfg_ff.occ_limit};
         default:                   prdata = {16'd0, cfg_ff.free_limit};
      endcase
   end

   always_comb begin
      item.cmd         = req_beam.cmd;
      item.point_x     = req_beam.point_x;
      item.point_y     = req_beam.point_y;
      item.heading     = req_beam.heading;
      item.beam_number = req_beam.beam_number;
      item.beam_range  = req_beam.beam_range;
   end

   lbog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_beam.valid),
      .req_ready (req_beam.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lbog_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .MAX_STEPS   (MAX_STEPS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .item   (item),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_cell)
   );

endmodule

[tb/sv/laser_beam_occupancy_grid_update_unit_tb.sv]
// Self-checking testbench of the laser beam occupancy grid update unit.
// Depends on lbog_pkg, lbog_req_if, lbog_rsp_if and the unit's top level.
module laser_beam_occupancy_grid_update_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GW = 256;
   localparam int GH = 256;
   localparam int STEPS = 63;
   localparam int FB = 8;
   localparam int PSH = FB + 15;
   localparam int IDLE_LIMIT = 200000;

   // Predicts the cell updates of each transaction and checks the results in order.
   class grid_scoreboard;
      lbog_pkg::cfg_type cfg;
      shortint cells [GW*GH];
      lbog_pkg::result_type pending [$];
      int errors;
      int matched;
      int beams;
      int landmarks;

      function void clear_all();
         foreach (cells[i]) cells[i] = 0;
         cfg.angle_start = 16'd0;
         cfg.angle_step = 16'd182;
         cfg.range_lower = 14'd0;
         cfg.range_upper = 14'd15872;
         cfg.free_inc = -16'sd216;
         cfg.occ_inc = 15'd216;
         cfg.occ_limit = 16'sd100;
         cfg.free_limit = -16'sd100;
      endfunction

      function void write_reg(lbog_pkg::reg_index_type r, logic [31:0] v);
         case (r)
            lbog_pkg::REG_ANGLE_START: cfg.angle_start = v[15:0];
            lbog_pkg::REG_ANGLE_STEP:  cfg.angle_step = v[15:0];
            lbog_pkg::REG_RANGE_LOWER: cfg.range_lower = v[13:0];
            lbog_pkg::REG_RANGE_UPPER: cfg.range_upper = v[13:0];
            lbog_pkg::REG_FREE_INC:    cfg.free_inc = v[15:0];
            lbog_pkg::REG_OCC_INC:     cfg.occ_inc = v[14:0];
            lbog_pkg::REG_OCC_LIMIT:   cfg.occ_limit = v[15:0];
            lbog_pkg::REG_FREE_LIMIT:  cfg.free_limit = v[15:0];
            default: ;
         endcase
      endfunction

      function longint turn_sine(logic [15:0] a);
         longint x, x2, t, m, s;
         x = a[13:0];
         if (a[14]) x = 16384 - x;
         x2 = (x * x) >>> 14;
         t = lbog_pkg::SIN_B - ((x2 * lbog_pkg::SIN_C) >>> 14);
         m = lbog_pkg::SIN_A - ((x2 * t) >>> 14);
         s = (x * m) >>> 14;
         return a[15] ? -s : s;
      endfunction

      // Nearest cell centre along one axis; off is twice the offset from it.
      function longint snap(longint v, longint half, output longint off);
         longint one, u, c;
         one = longint'(1) <<< PSH;
         u = v + half * one;
         c = (u >= 0) ? (u >>> PSH) : -((-u + one - 1) >>> PSH);
         off = 2 * (u - c * one) - one;
         return c;
      endfunction

      function bit find_cell(longint xh, longint yh, output int idx, output longint d2);
         longint ox, oy, col, row;
         col = snap(xh, GW / 2, ox);
         row = snap(yh, GH / 2, oy);
         idx = 0;
         d2 = 0;
         if (col < 0 || col >= GW || row < 0 || row >= GH) return 0;
         idx = int'(row * GW + col);
         d2 = ox * ox + oy * oy;
         return 1;
      endfunction

      function void update_cell(int idx, int inc);
         int v;
         lbog_pkg::result_type r;
         v = int'(cells[idx]) + inc;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         cells[idx] = shortint'(v);
         r.cell_index = idx[15:0];
         if (v >= int'(cfg.occ_limit)) r.cell_class = lbog_pkg::CLASS_OCCUPIED;
         else if (v <= int'(cfg.free_limit)) r.cell_class = lbog_pkg::CLASS_FREE;
         else r.cell_class = lbog_pkg::CLASS_UNDECIDED;
         r.cell_log_odds = v[15:0];
         r.last = 1'b0;
         pending.push_back(r);
      endfunction

      function void note_item(lbog_pkg::item_type it);
         longint px, py, rr, sn, cs, r, d2;
         longint third, tenth4, unit;
         logic [15:0] ang;
         int idx, inc, k, start_count;
         lbog_pkg::result_type tail;
         start_count = pending.size();
         px = longint'(it.point_x) * 32768;
         py = longint'(it.point_y) * 32768;
         // Squared distance thresholds, scaled by the doubling in snap.
         third = longint'(1) <<< (2 * PSH + 2);
         tenth4 = longint'(1) <<< (2 * PSH + 4);
         unit = longint'(1) <<< FB;
         if (it.cmd == lbog_pkg::CMD_LANDMARK) begin
            landmarks++;
            if (find_cell(px, py, idx, d2) && 9 * d2 < third)
               update_cell(idx, int'(cfg.occ_inc));
         end else begin
            beams++;
            rr = it.beam_range;
            ang = cfg.angle_start + it.beam_number * cfg.angle_step + it.heading;
            sn = turn_sine(ang);
            cs = turn_sine(ang + 16'd16384);
            if (rr < cfg.range_upper && rr >= cfg.range_lower) begin
               for (k = 0; k < STEPS && k * unit < rr + unit; k++) begin
                  r = k * unit;
                  if (find_cell(px + r * cs, py + r * sn, idx, d2)) begin
                     inc = 0;
                     if (9 * d2 < third && 2 * r <= 2 * rr - unit) inc = int'(cfg.free_inc);
                     else if (9 * d2 < third && 2 * r >= 2 * rr + unit)
                        inc = int'(cfg.occ_inc);
                     update_cell(idx, inc);
                  end
               end
               if (find_cell(px + rr * cs, py + rr * sn, idx, d2) && 25 * d2 < tenth4)
                  update_cell(idx, int'(cfg.occ_inc));
            end
         end
         if (pending.size() > start_count) begin
            tail = pending.pop_back();
            tail.last = 1'b1;
            pending.push_back(tail);
         end
      endfunction

      function void check_result(lbog_pkg::result_type got);
         lbog_pkg::result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected cell result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"cell result mismatch: expected idx %0d cls %0d lo %0d last %0d,",
                         " got idx %0d cls %0d lo %0d last %0d"},
                        want.cell_index, want.cell_class, want.cell_log_odds, want.last,
                        got.cell_index, got.cell_class, got.cell_log_odds, got.last);
         end else matched++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [lbog_pkg::ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   lbog_req_if req_beam ();
   lbog_rsp_if rsp_cell ();

   laser_beam_occupancy_grid_update_unit uut (
      .clock(clock), .reset(reset), .req_beam(req_beam.sink), .rsp_cell(rsp_cell.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   grid_scoreboard grid;
   int idle_cycles;
   bit stall_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results are checked at the rising edge; the watchdog counts idle cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_cell.valid && rsp_cell.ready) begin
            lbog_pkg::result_type got;
            got.cell_index = rsp_cell.cell_index;
            got.cell_class = rsp_cell.cell_class;
            got.cell_log_odds = rsp_cell.cell_log_odds;
            got.last = rsp_cell.last;
            grid.check_result(got);
         end
         if ((rsp_cell.valid && rsp_cell.ready) || (req_beam.valid && req_beam.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", grid.pending.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // The receiver runs on its own pattern: long open stretches and stall bursts.
   initial begin
      rsp_cell.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 15) == 0) stall_on = ~stall_on;
         rsp_cell.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   task automatic csr_write(lbog_pkg::reg_index_type r, logic [31:0] v);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= lbog_pkg::ADDR_W'(4 * int'(r));
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      grid.write_reg(r, v);
   endtask

   task automatic send_item(lbog_pkg::item_type it);
      req_beam.valid <= 1'b1;
      req_beam.cmd <= it.cmd;
      req_beam.point_x <= it.point_x;
      req_beam.point_y <= it.point_y;
      req_beam.heading <= it.heading;
      req_beam.beam_number <= it.beam_number;
      req_beam.beam_range <= it.beam_range;
      do @(posedge clock); while (!req_beam.ready);
      grid.note_item(it);
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_beam.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clock);
   endtask

   task automatic drain();
      while (grid.pending.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   function automatic lbog_pkg::item_type make_beam(logic [15:0] x, logic [15:0] y,
                                                    logic [15:0] hd, logic [9:0] bn,
                                                    logic [15:0] rg);
      lbog_pkg::item_type it;
      it.cmd = ~lbog_pkg::CMD_LANDMARK;
      it.point_x = x;
      it.point_y = y;
      it.heading = hd;
      it.beam_number = bn;
      it.beam_range = rg;
      return it;
   endfunction

   // Mostly short beams near the map with small ranges; some landmarks and wild values.
   function automatic lbog_pkg::item_type random_item();
      lbog_pkg::item_type it;
      int sel;
      sel = $urandom_range(0, 9);
      it = make_beam(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom), 10'($urandom), 16'($urandom));
      if (sel < 7) begin
         it.point_x = 16'($signed($urandom_range(0, 20000)) - 10000);
         it.point_y = 16'($signed($urandom_range(0, 20000)) - 10000);
         it.beam_range = (sel == 0) ? 16'($urandom_range(0, 16000))
                                    : 16'($urandom_range(0, 2000));
      end else if (sel == 7) begin
         it.cmd = lbog_pkg::CMD_LANDMARK;
         it.point_x = 16'(($urandom_range(0, 40) - 20) * 256 + 128 + $urandom_range(0, 80) - 40);
         it.point_y = 16'(($urandom_range(0, 40) - 20) * 256 + 128 + $urandom_range(0, 80) - 40);
      end else if (sel == 8) begin
         it.cmd = lbog_pkg::CMD_LANDMARK;
      end
      return it;
   endfunction

   task automatic run_random(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && count > 0) begin
            send_item(random_item());
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) drop_valid();
      end
      req_beam.valid <= 1'b0;
   endtask

   initial begin
      lbog_pkg::item_type it;
      grid = new();
      grid.clear_all();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_cycles = 0;
      stall_on = 1'b0;
      req_beam.valid = 1'b0;
      req_beam.cmd = 1'b0;
      req_beam.point_x = '0;
      req_beam.point_y = '0;
      req_beam.heading = '0;
      req_beam.beam_number = '0;
      req_beam.beam_range = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items: extremes, dropped beams, landmarks on and off centre.
      send_item(make_beam(16'd0, 16'd0, 16'd0, 10'd0, 16'd0));
      send_item(make_beam(16'd128, 16'd128, 16'd16384, 10'd0, 16'd1000));
      send_item(make_beam(16'h8000, 16'h8000, 16'hFFFF, 10'h3FF, 16'hFFFF));
      send_item(make_beam(16'h7FFF, 16'h7FFF, 16'd32768, 10'd5, 16'd15871));
      send_item(make_beam(16'd0, 16'd0, 16'd49152, 10'd0, 16'd15872));
      send_item(make_beam(-16'sd32000, 16'd0, 16'd0, 10'd0, 16'd15000));
      send_item(make_beam(16'd300, -16'sd700, 16'd8192, 10'd3, 16'd640));
      it = make_beam(16'd128, 16'd128, 16'hFFFF, 10'h3FF, 16'hFFFF);
      it.cmd = lbog_pkg::CMD_LANDMARK;
      send_item(it);
      it.point_x = 16'd200;
      send_item(it);
      it.point_x = 16'h7FFF;
      send_item(it);
      it.point_x = 16'h8000;
      it.point_y = 16'h8000;
      send_item(it);
      req_beam.valid <= 1'b0;
      drain();

      // Extreme increments drive saturation quickly on a few cells.
      csr_write(lbog_pkg::REG_FREE_INC, 32'hFFFF_8000);
      csr_write(lbog_pkg::REG_OCC_INC, 32'h7FFF);
      csr_write(lbog_pkg::REG_OCC_LIMIT, 32'h7FFF);
      csr_write(lbog_pkg::REG_FREE_LIMIT, 32'hFFFF_8000);
      csr_write(lbog_pkg::REG_ANGLE_START, 32'hFFFF);
      csr_write(lbog_pkg::REG_ANGLE_STEP, 32'hFFFF);
      csr_write(lbog_pkg::REG_RANGE_LOWER, 32'd512);
      csr_write(lbog_pkg::REG_RANGE_UPPER, 32'd4000);
      it = make_beam(16'd128, 16'd128, 16'd0, 10'd1, 16'd768);
      repeat (3) send_item(it);
      it.cmd = lbog_pkg::CMD_LANDMARK;
      repeat (3) send_item(it);
      send_item(make_beam(16'd0, 16'd0, 16'd0, 10'd0, 16'd511));
      send_item(make_beam(16'd0, 16'd0, 16'd0, 10'd0, 16'd4000));
      req_beam.valid <= 1'b0;
      drain();
      run_random(50);
      drain();

      // Mid settings, then the full range limits with zero increments.
      csr_write(lbog_pkg::REG_ANGLE_START, $urandom);
      csr_write(lbog_pkg::REG_ANGLE_STEP, $urandom_range(0, 2000));
      csr_write(lbog_pkg::REG_RANGE_LOWER, 32'd0);
      csr_write(lbog_pkg::REG_RANGE_UPPER, 32'd15872);
      csr_write(lbog_pkg::REG_FREE_INC, 32'hFFFF_FF00);
      csr_write(lbog_pkg::REG_OCC_INC, 32'd300);
      csr_write(lbog_pkg::REG_OCC_LIMIT, 32'd200);
      csr_write(lbog_pkg::REG_FREE_LIMIT, 32'hFFFF_FF38);
      run_random(55);
      drain();

      csr_write(lbog_pkg::REG_FREE_INC, 32'd0);
      csr_write(lbog_pkg::REG_OCC_INC, 32'd0);
      csr_write(lbog_pkg::REG_OCC_LIMIT, 32'hFFFF_8000);
      csr_write(lbog_pkg::REG_FREE_LIMIT, 32'h7FFF);
      csr_write(lbog_pkg::REG_RANGE_UPPER, 32'd0);
      send_item(make_beam(16'd0, 16'd0, 16'd0, 10'd0, 16'd0));
      csr_write(lbog_pkg::REG_RANGE_UPPER, 32'd2000);
      run_random(40);
      drain();

      $display("%0d beams and %0d landmarks sent, %0d cell results matched.",
               grid.beams, grid.landmarks, grid.matched);
      $display("Register settings covered increment, limit and range extremes.");
      if (grid.errors == 0 && grid.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", grid.errors);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
